FILE: hdl/blp_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package blp_pkg;

  // coordinate and error-term widths
  localparam int CRD_W = 6;
  localparam int ERR_W = CRD_W + 2;

  // depth of the command queue between front and back
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // one line request
  typedef struct packed {
    logic [CRD_W-1:0] start_x;
    logic [CRD_W-1:0] start_y;
    logic [CRD_W-1:0] end_x;
    logic [CRD_W-1:0] end_y;
  } req_t;

  // one raster point
  typedef struct packed {
    logic [CRD_W-1:0] point_x;
    logic [CRD_W-1:0] point_y;
    logic             last_point;
  } pt_t;

  // classified line, ready for stepping
  typedef struct packed {
    logic [CRD_W-1:0]        x;
    logic [CRD_W-1:0]        y;
    logic                    x_major;
    logic [CRD_W-1:0]        maj_inc;   // +1, -1 or 0, modulo 2^CRD_W
    logic [CRD_W-1:0]        min_inc;
    logic [CRD_W-1:0]        count;     // steps left after the current point
    logic [CRD_W:0]          two_maj;
    logic [CRD_W:0]          two_min;
    logic signed [ERR_W-1:0] err;
    logic                    tie_ok;    // major direction positive
  } cmd_t;

  // queue status seen by its neighbors
  typedef struct packed {
    logic            empty;
    logic            full;
    logic [Q_CW-1:0] count;
  } q_stat_t;

endpackage

`default_nettype wire

FILE: hdl/blp_front.sv
`timescale 1ns / 1ps
`default_nettype none

module blp_front import blp_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire req_t in_word,
  output logic      q_push,
  input  wire logic q_full,
  output cmd_t      q_word
);

  localparam logic [CRD_W-1:0] MASK = CRD_W'((1 << COORD_BITS) - 1);

  logic [CRD_W-1:0] x0, y0, x1, y1;
  logic [CRD_W-1:0] adx, ady, maj, mnr, inc_x, inc_y;
  logic             x_major;
  cmd_t             cmd_nxt;
  cmd_t             cmd_r;
  logic             valid_r;
  logic             load;

  // mask coordinates and classify the line
  always_comb begin
    x0 = in_word.start_x & MASK;
    y0 = in_word.start_y & MASK;
    x1 = in_word.end_x & MASK;
    y1 = in_word.end_y & MASK;
    adx = (x1 >= x0) ? (x1 - x0) : (x0 - x1);
    ady = (y1 >= y0) ? (y1 - y0) : (y0 - y1);
    inc_x = (x1 > x0) ? CRD_W'(1) : ((x1 < x0) ? '1 : '0);
    inc_y = (y1 > y0) ? CRD_W'(1) : ((y1 < y0) ? '1 : '0);
    x_major = (adx >= ady);
    maj = x_major ? adx : ady;
    mnr = x_major ? ady : adx;

    cmd_nxt.x       = x0;
    cmd_nxt.y       = y0;
    cmd_nxt.x_major = x_major;
    cmd_nxt.maj_inc = x_major ? inc_x : inc_y;
    cmd_nxt.min_inc = x_major ? inc_y : inc_x;
    cmd_nxt.count   = maj;
    cmd_nxt.two_maj = {maj, 1'b0};
    cmd_nxt.two_min = {mnr, 1'b0};
    cmd_nxt.err     = $signed({1'b0, mnr, 1'b0}) - $signed({2'b00, maj});
    cmd_nxt.tie_ok  = x_major ? (x1 > x0) : (y1 > y0);
  end

  // one holding stage; it frees whenever the queue takes its word
  assign load    = !valid_r || !q_full;
  assign in_full = !load;
  assign q_push  = valid_r;
  assign q_word  = cmd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (load) begin
      valid_r <= in_push;
      cmd_r   <= cmd_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: hdl/blp_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module blp_queue import blp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push,
  input  wire cmd_t push_word,
  input  wire logic pop,
  output cmd_t      head,
  output q_stat_t   stat
);

  cmd_t            slot_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_r, rd_r;
  logic [Q_CW-1:0] count_r;
  logic            do_push, do_pop;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == Q_CW'(Q_DEPTH));
  assign stat.count = count_r;
  assign head       = slot_r[rd_r];

  assign do_push = push && !stat.full;
  assign do_pop  = pop && !stat.empty;

  // pointer wrap at the queue depth
  function automatic logic [Q_AW-1:0] bump(input logic [Q_AW-1:0] p);
    return (p == Q_AW'(Q_DEPTH - 1)) ? '0 : p + Q_AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r    <= '0;
      rd_r    <= '0;
      count_r <= '0;
    end else begin
      if (do_push) begin
        slot_r[wr_r] <= push_word;
        wr_r         <= bump(wr_r);
      end
      if (do_pop) begin
        rd_r <= bump(rd_r);
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + Q_CW'(1);
      end else if (do_pop && !do_push) begin
        count_r <= count_r - Q_CW'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: hdl/blp_back.sv
`timescale 1ns / 1ps
`default_nettype none

module blp_back import blp_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic q_empty,
  input  wire cmd_t q_head,
  output logic      q_pop,
  output logic      busy,
  output logic      out_empty,
  input  wire logic out_pop,
  output pt_t       out_word
);

  typedef enum logic {ST_IDLE, ST_RUN} state_t;

  state_t           state_r;
  cmd_t             cur_r;
  cmd_t             step;
  pt_t              out_r;
  logic             out_valid_r;
  logic             out_valid_nxt;
  logic             adv, take, last;
  logic [CRD_W-1:0] maj_c, min_c, maj_n, min_n;
  logic [ERR_W-1:0] err_w;

  assign q_pop     = (state_r == ST_IDLE) && !q_empty;
  assign busy      = (state_r == ST_RUN);
  assign out_empty = !out_valid_r;
  assign out_word  = out_r;
  assign adv       = !out_valid_r || out_pop;
  assign last      = (cur_r.count == '0);

  // output word holds until popped; a new point refills it
  assign out_valid_nxt = ((state_r == ST_RUN) && adv) || (out_valid_r && !out_pop);

  // one Bresenham step
  always_comb begin
    take  = (cur_r.err > 0) || ((cur_r.err == 0) && cur_r.tie_ok);
    maj_c = cur_r.x_major ? cur_r.x : cur_r.y;
    min_c = cur_r.x_major ? cur_r.y : cur_r.x;
    maj_n = maj_c + cur_r.maj_inc;
    min_n = take ? (min_c + cur_r.min_inc) : min_c;
    err_w = cur_r.err + ERR_W'(cur_r.two_min)
          - (take ? ERR_W'(cur_r.two_maj) : '0);

    step       = cur_r;
    step.x     = cur_r.x_major ? maj_n : min_n;
    step.y     = cur_r.x_major ? min_n : maj_n;
    step.count = cur_r.count - CRD_W'(1);
    step.err   = err_w;
  end

  // sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      case (state_r)
        ST_IDLE: begin
          if (!q_empty) begin
            cur_r   <= q_head;
            state_r <= ST_RUN;
          end
        end
        ST_RUN: begin
          if (adv) begin
            out_r.point_x    <= cur_r.x;
            out_r.point_y    <= cur_r.y;
            out_r.last_point <= last;
            if (last) begin
              state_r <= ST_IDLE;
            end else begin
              cur_r <= step;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: hdl/bresenham_line_points.sv
`timescale 1ns / 1ps
`default_nettype none

// Line rasterizer. Each word pushed in is a line from (start_x, start_y) to
// (end_x, end_y); the block pops out every raster point from start to end,
// max(|dx|,|dy|)+1 words, with last_point set on the end point. Coordinates
// are masked to COORD_BITS bits. The stepper emits one point per cycle while
// the receiver keeps popping, and it loads each line from the command queue
// in its idle state before it steps that line. A request is classified on
// entry and waits in a two-deep queue, so up to three requests can be
// taken while a long line is still being drawn.
module bresenham_line_points import blp_pkg::*; #(
  parameter int COORD_BITS = 6
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_push,
  output logic      in_full,
  input  wire req_t in_word,
  output logic      out_empty,
  input  wire logic out_pop,
  output pt_t       out_word
);

  logic    q_push, q_pop, busy;
  cmd_t    q_in, q_head;
  q_stat_t q_stat;

  blp_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_push (in_push),
    .in_full (in_full),
    .in_word (in_word),
    .q_push  (q_push),
    .q_full  (q_stat.full),
    .q_word  (q_in)
  );

  blp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_word (q_in),
    .pop       (q_pop),
    .head      (q_head),
    .stat      (q_stat)
  );

  blp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_empty   (q_stat.empty),
    .q_head    (q_head),
    .q_pop     (q_pop),
    .busy      (busy),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

`ifndef SYNTHESIS
  // queue occupancy never exceeds its depth
  a_q_bound: assert property (@(posedge clk) disable iff (!rst_n)
    q_stat.count <= Q_CW'(Q_DEPTH))
    else $error("command queue overfilled");

  // the stepper takes a new line only while idle
  a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !busy && !q_stat.empty)
    else $error("queue popped while stepping");

  // an accepted request leaves the entry stage occupied
  a_front_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (in_push && !in_full) |=> q_push)
    else $error("accepted request lost at entry");

  // reset leaves the block ready and with nothing to deliver
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !in_full && out_empty)
    else $error("block not clear after reset");
`endif

endmodule

`default_nettype wire

FILE: tb/tb_bresenham_line_points.sv
`timescale 1ns / 1ps

module tb_bresenham_line_points;
  import blp_pkg::*;

  localparam int RUN_MAX      = 1 << CRD_W;  // longest run of points for one line
  localparam int RANDOM_LINES = 300;
  localparam int STALL_LIMIT  = 4000;        // cycles with no word moving on either side
  localparam int SETTLE_CYC   = 80;          // one full line plus load, with margin
  localparam int HOLD_CYC     = 400;         // long receiver hold-off
  localparam int HOLD_AFTER   = 200;         // points seen before the hold-off starts

  // one pending line; drain means wait until every point so far has come back
  typedef struct {
    req_t word;
    bit   drain;
  } line_item_t;

  logic clk     = 1'b0;
  logic rst_n   = 1'b0;
  logic in_push = 1'b0;
  req_t in_word = '0;
  logic out_pop = 1'b0;
  logic in_full;
  logic out_empty;
  pt_t  out_word;

  line_item_t line_q[$];
  pt_t        point_q[$];
  int         errors      = 0;
  int         points_seen = 0;

  bresenham_line_points i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_full   (in_full),
    .in_word   (in_word),
    .out_empty (out_empty),
    .out_pop   (out_pop),
    .out_word  (out_word)
  );

  always #1 clk = ~clk;

  task automatic report_mismatch(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  function automatic void queue_point(input int px, input int py, input bit last);
    pt_t pt;
    pt.point_x    = px[CRD_W-1:0];
    pt.point_y    = py[CRD_W-1:0];
    pt.last_point = last;
    point_q.insert(point_q.size(), pt);
  endfunction

  // expected raster points of one line, start to end
  function automatic void predict_points(input req_t line);
    int cx, cy, ex, ey, dx, dy, sx, sy, adx, ady, err, n;
    cx  = line.start_x;
    cy  = line.start_y;
    ex  = line.end_x;
    ey  = line.end_y;
    dx  = ex - cx;
    dy  = ey - cy;
    sx  = (dx > 0) ? 1 : ((dx < 0) ? -1 : 0);
    sy  = (dy > 0) ? 1 : ((dy < 0) ? -1 : 0);
    adx = (dx < 0) ? -dx : dx;
    ady = (dy < 0) ? -dy : dy;
    n   = 0;
    if (adx >= ady) begin
      // x major; a tie on the error steps y only when moving toward +x
      err = 2 * ady - adx;
      while (cx != ex && n < RUN_MAX - 1) begin
        queue_point(cx, cy, 1'b0);
        n++;
        if (err > 0 || (err == 0 && sx > 0)) begin
          err -= 2 * adx;
          cy  += sy;
        end
        err += 2 * ady;
        cx  += sx;
      end
    end else begin
      err = 2 * adx - ady;
      while (cy != ey && n < RUN_MAX - 1) begin
        queue_point(cx, cy, 1'b0);
        n++;
        if (err > 0 || (err == 0 && sy > 0)) begin
          err -= 2 * ady;
          cx  += sx;
        end
        err += 2 * adx;
        cy  += sy;
      end
    end
    queue_point(cx, cy, 1'b1);
  endfunction

  // driver: bursts of lines with random gaps, optional drain before a line
  int burst_left = 1;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        predict_points(in_word);
      end
      if (in_push && in_full) begin
        // word still waiting, hold it
      end else if (gap_left > 0) begin
        gap_left--;
        in_push <= 1'b0;
      end else if (line_q.size() > 0 && !(line_q[0].drain && point_q.size() > 0)) begin
        in_word <= line_q[0].word;
        in_push <= 1'b1;
        void'(line_q.pop_front());
        burst_left--;
        if (burst_left == 0) begin
          burst_left = $urandom_range(1, 12);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
      end else begin
        in_push <= 1'b0;
      end
    end
  end

  // monitor: check each popped point, stall on a rotating pattern
  bit [15:0] pop_pattern = 16'hffff;
  int        pop_phase   = 0;
  int        hold_left   = 0;
  bit        hold_done   = 1'b0;

  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        points_seen++;
        if (point_q.size() == 0) begin
          report_mismatch($sformatf("unexpected point (%0d,%0d) last=%0b",
                                    out_word.point_x, out_word.point_y,
                                    out_word.last_point));
        end else begin
          if (out_word.point_x !== point_q[0].point_x)
            report_mismatch($sformatf("point_x got %0d want %0d",
                                      out_word.point_x, point_q[0].point_x));
          if (out_word.point_y !== point_q[0].point_y)
            report_mismatch($sformatf("point_y got %0d want %0d",
                                      out_word.point_y, point_q[0].point_y));
          if (out_word.last_point !== point_q[0].last_point)
            report_mismatch($sformatf("last_point got %0b want %0b",
                                      out_word.last_point, point_q[0].last_point));
          void'(point_q.pop_front());
        end
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else if (!hold_done && points_seen >= HOLD_AFTER) begin
        // long hold-off so the block backs up and raises full
        hold_done = 1'b1;
        hold_left = HOLD_CYC;
        out_pop  <= 1'b0;
      end else begin
        if (pop_phase == 0) begin
          pop_pattern = ($urandom_range(0, 3) == 0) ? 16'hffff : 16'($urandom());
          if (pop_pattern == '0)
            pop_pattern = 16'h0001;
        end
        out_pop   <= pop_pattern[pop_phase[3:0]];
        pop_phase  = (pop_phase + 1) % 64;
      end
    end
  end

  // watchdog on cycles where no word moves
  int quiet_cyc = 0;

  always @(posedge clk) begin
    if ((in_push && !in_full) || (out_pop && !out_empty))
      quiet_cyc = 0;
    else
      quiet_cyc++;
    if (quiet_cyc >= STALL_LIMIT) begin
      $display("timeout: no progress for %0d cycles", STALL_LIMIT);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  function automatic line_item_t make_line(input int sx0, input int sy0,
                                           input int ex0, input int ey0,
                                           input bit drain);
    line_item_t it;
    it.word.start_x = sx0[CRD_W-1:0];
    it.word.start_y = sy0[CRD_W-1:0];
    it.word.end_x   = ex0[CRD_W-1:0];
    it.word.end_y   = ey0[CRD_W-1:0];
    it.drain        = drain;
    return it;
  endfunction

  // append one line to the pending list
  function automatic void add_line(input line_item_t it);
    line_q.insert(line_q.size(), it);
  endfunction

  function automatic int clamp_crd(input int v);
    return (v < 0) ? 0 : ((v > RUN_MAX - 1) ? RUN_MAX - 1 : v);
  endfunction

  initial begin
    int x0, y0, x1, y1, kind;
    bit drain;

    // single point at both corners
    add_line(make_line(0, 0, 0, 0, 1'b0));
    add_line(make_line(63, 63, 63, 63, 1'b0));
    // full-length horizontal and vertical, both directions
    add_line(make_line(0, 17, 63, 17, 1'b0));
    add_line(make_line(63, 40, 0, 40, 1'b0));
    add_line(make_line(22, 0, 22, 63, 1'b0));
    add_line(make_line(45, 63, 45, 0, 1'b0));
    // full diagonals
    add_line(make_line(0, 0, 63, 63, 1'b0));
    add_line(make_line(63, 0, 0, 63, 1'b0));
    add_line(make_line(63, 63, 0, 0, 1'b0));
    add_line(make_line(0, 63, 63, 0, 1'b0));
    // error ties on each major axis, drawn both ways
    add_line(make_line(0, 0, 4, 2, 1'b0));
    add_line(make_line(4, 2, 0, 0, 1'b0));
    add_line(make_line(0, 0, 2, 4, 1'b0));
    add_line(make_line(2, 4, 0, 0, 1'b0));
    // one line per octant
    add_line(make_line(10, 10, 20, 13, 1'b0));
    add_line(make_line(10, 10, 13, 20, 1'b0));
    add_line(make_line(10, 10, 7, 20, 1'b0));
    add_line(make_line(10, 10, 0, 13, 1'b0));
    add_line(make_line(10, 10, 0, 7, 1'b0));
    add_line(make_line(10, 10, 7, 0, 1'b0));
    add_line(make_line(10, 10, 13, 0, 1'b0));
    add_line(make_line(10, 10, 20, 7, 1'b0));

    // random lines: short ones, single points, axis-aligned and full range
    for (int i = 0; i < RANDOM_LINES; i++) begin
      kind  = $urandom_range(0, 9);
      x0    = $urandom_range(0, RUN_MAX - 1);
      y0    = $urandom_range(0, RUN_MAX - 1);
      x1    = $urandom_range(0, RUN_MAX - 1);
      y1    = $urandom_range(0, RUN_MAX - 1);
      drain = (i == RANDOM_LINES / 2) || ($urandom_range(0, 39) == 0);
      if (kind < 3) begin
        x1 = clamp_crd(x0 + $urandom_range(0, 8) - 4);
        y1 = clamp_crd(y0 + $urandom_range(0, 8) - 4);
      end else if (kind == 3) begin
        x1 = x0;
        y1 = y0;
      end else if (kind == 4) begin
        if ($urandom_range(0, 1) == 1)
          y1 = y0;
        else
          x1 = x0;
      end
      add_line(make_line(x0, y0, x1, y1, drain));
    end

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    while (line_q.size() > 0 || in_push || point_q.size() > 0)
      @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);

    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

FILE: files.f
hdl/blp_pkg.sv
hdl/blp_front.sv
hdl/blp_queue.sv
hdl/blp_back.sv
hdl/bresenham_line_points.sv
tb/tb_bresenham_line_points.sv
